// ===== sv/nfa_wa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_wa_pkg
// Operation codes, register indexes and controller states shared by the NFA
// word acceptor.
// ----------------------------------------------------------------------------
package nfa_wa_pkg;

   localparam int CsrDataW = 27;
   localparam int FieldW   = 5;
   localparam int OpW      = 2;

   typedef enum logic [OpW-1:0] {
      OP_ADD    = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_LETTER = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef enum logic {
      CSR_START_STATE = 1'b0,
      CSR_ACCEPT_MASK = 1'b1
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ADD_RD = 6'b000100,
      ST_ADD_WR = 6'b001000,
      ST_STEP   = 6'b010000,
      ST_FINISH = 6'b100000
   } ctrl_state_type;

endpackage

// ===== sv/nfa_wa_ram.sv =====
// ----------------------------------------------------------------------------
// nfa_wa_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module nfa_wa_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 702
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/nfa_word_acceptor_unit.sv =====
// ----------------------------------------------------------------------------
// nfa_word_acceptor_unit
// Runs a nondeterministic finite automaton over words of letters a..z.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. Add items with all
// fields in range OR a target state into the next-state mask of one (state,
// letter) entry by way of accept, read and write back. Begin items load the
// start state into the active set, or empty it if the start state is out of
// range. Letter items walk every state through the transition memory, one
// read per cycle; an out-of-range letter empties the active set instead. The
// result of an end item appears on rsp_accepted, marked by rsp_valid, for
// one cycle in the cycle after acceptance. The memory read port sets the
// letter rate. Nothing holds results off, so the unit never waits on the
// receiver. After reset the unit clears the transition memory, one entry per
// cycle, while busy is high; the CSR port is live throughout. CSR writes
// should be made only while busy is low.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_unit #(
   parameter int NUM_STATES    = 27,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [nfa_wa_pkg::OpW-1:0]       req_op,
   input  logic [nfa_wa_pkg::FieldW-1:0]    req_from_state,
   input  logic [nfa_wa_pkg::FieldW-1:0]    req_to_state,
   input  logic [nfa_wa_pkg::FieldW-1:0]    req_letter,
   output logic                             rsp_valid,
   output logic                             rsp_accepted,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [nfa_wa_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int Depth = NUM_STATES * ALPHABET_SIZE;
   localparam int AddrW = $clog2(Depth);
   localparam int IdxW  = $clog2(NUM_STATES);
   localparam int ExtW  = (NUM_STATES > nfa_wa_pkg::CsrDataW) ? NUM_STATES
                                                               : nfa_wa_pkg::CsrDataW;

   nfa_wa_pkg::ctrl_state_type state_ff, state_in;

   logic [AddrW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [AddrW-1:0]                  add_addr_ff, add_addr_in;
   logic [NUM_STATES-1:0]             add_bit_ff, add_bit_in;
   logic [nfa_wa_pkg::FieldW-1:0]     letter_ff, letter_in;
   logic [IdxW-1:0]                   idx_ff, idx_in;
   logic                              pend_ff, pend_in;
   logic [NUM_STATES-1:0]             acc_ff, acc_in;
   logic [NUM_STATES-1:0]             active_ff, active_in;
   logic [nfa_wa_pkg::FieldW-1:0]     start_state_ff, start_state_in;
   logic [nfa_wa_pkg::CsrDataW-1:0]   accept_mask_ff, accept_mask_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_accepted_ff, rsp_accepted_in;

   logic                              accept;
   logic                              src_ok, dst_ok, let_ok, start_ok;
   logic [ExtW-1:0]                   accept_ext;
   logic [NUM_STATES-1:0]             accept_bits;
   logic [NUM_STATES-1:0]             step_data;

   logic                              ram_wr_en, ram_rd_en;
   logic [AddrW-1:0]                  ram_wr_addr, ram_rd_addr;
   logic [NUM_STATES-1:0]             ram_wr_data, ram_rd_data;

   nfa_wa_ram #(
      .WIDTH (NUM_STATES),
      .DEPTH (Depth)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy   = (state_ff != nfa_wa_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign src_ok   = (32'(req_from_state) < NUM_STATES);
   assign dst_ok   = (32'(req_to_state) < NUM_STATES);
   assign let_ok   = (32'(req_letter) < ALPHABET_SIZE);
   assign start_ok = (32'(start_state_ff) < NUM_STATES);

   assign accept_ext  = ExtW'(accept_mask_ff);
   assign accept_bits = accept_ext[NUM_STATES-1:0];
   assign step_data   = pend_ff ? ram_rd_data : '0;

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = add_addr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = add_addr_ff;
      ram_wr_data = ram_rd_data | add_bit_ff;
      case (state_ff)
         nfa_wa_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
         end
         nfa_wa_pkg::ST_ADD_RD: begin
            ram_rd_en = 1'b1;
         end
         nfa_wa_pkg::ST_ADD_WR: begin
            ram_wr_en = 1'b1;
         end
         nfa_wa_pkg::ST_STEP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AddrW'(32'(idx_ff) * ALPHABET_SIZE + 32'(letter_ff));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      add_addr_in     = add_addr_ff;
      add_bit_in      = add_bit_ff;
      letter_in       = letter_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      acc_in          = acc_ff;
      active_in       = active_ff;
      rsp_valid_in    = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      start_state_in  = start_state_ff;
      accept_mask_in  = accept_mask_ff;

      if (csr_we) begin
         case (nfa_wa_pkg::csr_index_type'(csr_index))
            nfa_wa_pkg::CSR_START_STATE: begin
               start_state_in = csr_wdata[nfa_wa_pkg::FieldW-1:0];
            end
            nfa_wa_pkg::CSR_ACCEPT_MASK: begin
               accept_mask_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         nfa_wa_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == AddrW'(Depth - 1)) begin
               state_in = nfa_wa_pkg::ST_IDLE;
            end
         end
         nfa_wa_pkg::ST_IDLE: begin
            if (start) begin
               case (nfa_wa_pkg::op_type'(req_op))
                  nfa_wa_pkg::OP_ADD: begin
                     add_addr_in = AddrW'(32'(req_from_state) * ALPHABET_SIZE
                                          + 32'(req_letter));
                     add_bit_in  = NUM_STATES'(1) << req_to_state;
                     if (src_ok && dst_ok && let_ok) begin
                        state_in = nfa_wa_pkg::ST_ADD_RD;
                     end
                  end
                  nfa_wa_pkg::OP_BEGIN: begin
                     active_in = start_ok ? (NUM_STATES'(1) << start_state_ff) : '0;
                  end
                  nfa_wa_pkg::OP_LETTER: begin
                     letter_in = req_letter;
                     idx_in    = '0;
                     pend_in   = 1'b0;
                     acc_in    = '0;
                     if (let_ok) begin
                        state_in = nfa_wa_pkg::ST_STEP;
                     end else begin
                        active_in = '0;
                     end
                  end
                  nfa_wa_pkg::OP_END: begin
                     rsp_valid_in    = 1'b1;
                     rsp_accepted_in = |(active_ff & accept_bits);
                  end
                  default: begin
                  end
               endcase
            end
         end
         nfa_wa_pkg::ST_ADD_RD: begin
            state_in = nfa_wa_pkg::ST_ADD_WR;
         end
         nfa_wa_pkg::ST_ADD_WR: begin
            state_in = nfa_wa_pkg::ST_IDLE;
         end
         nfa_wa_pkg::ST_STEP: begin
            acc_in  = acc_ff | step_data;
            pend_in = active_ff[idx_ff];
            idx_in  = idx_ff + IdxW'(1);
            if (idx_ff == IdxW'(NUM_STATES - 1)) begin
               state_in = nfa_wa_pkg::ST_FINISH;
            end
         end
         nfa_wa_pkg::ST_FINISH: begin
            active_in = acc_ff | step_data;
            state_in  = nfa_wa_pkg::ST_IDLE;
         end
         default: begin
            state_in = nfa_wa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= nfa_wa_pkg::ST_CLEAR;
         clr_addr_ff    <= '0;
         active_ff      <= '0;
         start_state_ff <= '0;
         accept_mask_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         active_ff      <= active_in;
         start_state_ff <= start_state_in;
         accept_mask_ff <= accept_mask_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_addr_ff     <= add_addr_in;
      add_bit_ff      <= add_bit_in;
      letter_ff       <= letter_in;
      idx_ff          <= idx_in;
      pend_ff         <= pend_in;
      acc_ff          <= acc_in;
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   // A result only follows an end item accepted in the previous cycle.
   a_rsp_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept && req_op == nfa_wa_pkg::OP_END))
      else $error("result without an end item");

   // The table is never read and written in the same cycle.
   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("table read and write overlap");

   // A write-back always follows the read of the same entry.
   a_add_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == nfa_wa_pkg::ST_ADD_WR |-> $past(state_ff == nfa_wa_pkg::ST_ADD_RD))
      else $error("write-back without a read");

   // The letter walk ends only after the last state has been read.
   a_step_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == nfa_wa_pkg::ST_FINISH |->
         $past(state_ff == nfa_wa_pkg::ST_STEP && idx_ff == IdxW'(NUM_STATES - 1)))
      else $error("letter walk ended early");

endmodule
